/* design/sdgf_pkg.sv */
// Shared types and constants for the signed decimal glyph formatter.
package sdgf_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned GLYPH_W    = 4;
  localparam int unsigned MAX_SLOTS  = 8;
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned CONV_STEPS = VALUE_W;
  localparam int unsigned CNT_W      = $clog2(CONV_STEPS);
  localparam int unsigned SLOTS_W    = 4;
  localparam int unsigned NDIG_W     = 4;

  typedef logic [GLYPH_W-1:0] glyph_t;

  localparam glyph_t GLYPH_MINUS = glyph_t'(10);
  localparam glyph_t GLYPH_BLANK = glyph_t'(11);

  // APB register index
  localparam int unsigned REG_DIGIT_SLOTS = 0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic norm;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic norm_more;
  } status_t;

endpackage

/* design/sdgf_ctrl.sv */
// Sequencer for load, binary-to-BCD steps, digit alignment and result hand-off.
module sdgf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  sdgf_pkg::status_t status_i,
  output sdgf_pkg::cmd_t    cmd_o
);
  import sdgf_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_CONV;
      ST_CONV: if (cnt_q == CNT_W'(CONV_STEPS - 1)) state_d = ST_NORM;
      ST_NORM: if (!status_i.norm_more) state_d = ST_EMIT;
      ST_EMIT: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    cnt_d      = cnt_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        cnt_d      = '0;
      end
      ST_CONV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + CNT_W'(1);
      end
      ST_NORM: cmd_o.norm = status_i.norm_more;
      ST_EMIT: cmd_o.emit = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.emit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* design/sdgf_dpath.sv */
// Magnitude, shift-add-3 BCD converter, leading-zero alignment and glyph row register.
module sdgf_dpath (
  input  logic                                   clk_i,
  input  sdgf_pkg::cmd_t                         cmd_i,
  output sdgf_pkg::status_t                      status_o,
  input  logic signed [sdgf_pkg::VALUE_W-1:0]    value_i,
  input  logic [sdgf_pkg::SLOTS_W-1:0]           used_i,
  output sdgf_pkg::glyph_t [sdgf_pkg::MAX_SLOTS-1:0] glyphs_o
);
  import sdgf_pkg::*;

  logic [VALUE_W-1:0]                 mag_q, mag_d;
  logic [BCD_DIGITS-1:0][3:0]         bcd_q, bcd_d, bcd_adj;
  logic                               neg_q, neg_d;
  logic [NDIG_W-1:0]                  ndig_q, ndig_d;
  glyph_t [MAX_SLOTS-1:0]             glyph_q, glyph_d;

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
  end

  // most significant digit sits in bcd_q[BCD_DIGITS-1]
  assign status_o.norm_more = (bcd_q[BCD_DIGITS-1] == 4'd0) && (ndig_q > NDIG_W'(1));

  always_comb begin
    mag_d  = mag_q;
    bcd_d  = bcd_q;
    neg_d  = neg_q;
    ndig_d = ndig_q;
    if (cmd_i.load) begin
      neg_d  = value_i[VALUE_W-1];
      mag_d  = value_i[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value_i)) : VALUE_W'(value_i);
      bcd_d  = '0;
      ndig_d = NDIG_W'(BCD_DIGITS);
    end else if (cmd_i.step) begin
      {bcd_d, mag_d} = {bcd_adj, mag_q} << 1;
    end else if (cmd_i.norm) begin
      bcd_d  = {bcd_q[BCD_DIGITS-2:0], 4'd0};
      ndig_d = ndig_q - NDIG_W'(1);
    end
  end

  always_comb begin
    logic [SLOTS_W-1:0] used;
    logic [NDIG_W-1:0]  k;
    logic [NDIG_W-1:0]  idx;
    used = (used_i > SLOTS_W'(MAX_SLOTS)) ? SLOTS_W'(MAX_SLOTS) : used_i;
    for (int p = 0; p < MAX_SLOTS; p++) begin
      k   = neg_q ? NDIG_W'(p - 1) : NDIG_W'(p);
      idx = NDIG_W'(BCD_DIGITS - 1) - k;
      if (SLOTS_W'(p) >= used) begin
        glyph_d[p] = GLYPH_BLANK;
      end else if (neg_q && (p == 0)) begin
        glyph_d[p] = GLYPH_MINUS;
      end else if (k < ndig_q) begin
        glyph_d[p] = bcd_q[idx];
      end else begin
        glyph_d[p] = GLYPH_BLANK;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    neg_q  <= neg_d;
    ndig_q <= ndig_d;
    if (cmd_i.emit) glyph_q <= glyph_d;
  end

  assign glyphs_o = glyph_q;

endmodule

/* design/signed_decimal_glyph_formatter_unit.sv */
// Top level: APB slot-count register, sequencer and conversion datapath.
// An item runs these steps from acceptance to result: the value is loaded
// at the accepting edge, then come 32 shift-add-3 steps of the binary-to-BCD
// converter, then alignment steps that shift out leading zero digits until
// the leading digit is found (at most nine shifts), and last a write of the
// glyph row register. The next item is accepted in the cycle after the row
// is written. A new item is accepted while the previous row still waits in
// the output register; a waiting row only holds off the write of the next
// one. digit_slots lies at byte address 0, reset 8; values above 8 act as 8
// and 0 blanks every slot.
module signed_decimal_glyph_formatter_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [sdgf_pkg::VALUE_W-1:0]  value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [sdgf_pkg::GLYPH_W-1:0]         glyph_0_o,
  output logic [sdgf_pkg::GLYPH_W-1:0]         glyph_1_o,
  output logic [sdgf_pkg::GLYPH_W-1:0]         glyph_2_o,
  output logic [sdgf_pkg::GLYPH_W-1:0]         glyph_3_o,
  output logic [sdgf_pkg::GLYPH_W-1:0]         glyph_4_o,
  output logic [sdgf_pkg::GLYPH_W-1:0]         glyph_5_o,
  output logic [sdgf_pkg::GLYPH_W-1:0]         glyph_6_o,
  output logic [sdgf_pkg::GLYPH_W-1:0]         glyph_7_o
);
  import sdgf_pkg::*;

  logic [SLOTS_W-1:0]     slots_q, slots_d;
  logic                   reg_sel;
  cmd_t                   cmd;
  status_t                status;
  glyph_t [MAX_SLOTS-1:0] glyphs;

  assign pready  = 1'b1;
  // word index is paddr[2]
  assign reg_sel = (32'(paddr[2]) == REG_DIGIT_SLOTS);
  assign prdata  = reg_sel ? 32'(slots_q) : 32'd0;

  always_comb begin
    slots_d = slots_q;
    if (psel && penable && pwrite && pready && reg_sel) slots_d = pwdata[SLOTS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) slots_q <= SLOTS_W'(MAX_SLOTS);
    else         slots_q <= slots_d;
  end

  sdgf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sdgf_dpath u_dpath (
    .clk_i    (clk_i),
    .cmd_i    (cmd),
    .status_o (status),
    .value_i  (value_i),
    .used_i   (slots_q),
    .glyphs_o (glyphs)
  );

  assign glyph_0_o = glyphs[0];
  assign glyph_1_o = glyphs[1];
  assign glyph_2_o = glyphs[2];
  assign glyph_3_o = glyphs[3];
  assign glyph_4_o = glyphs[4];
  assign glyph_5_o = glyphs[5];
  assign glyph_6_o = glyphs[6];
  assign glyph_7_o = glyphs[7];

endmodule

/* design/sdgf_checker.sv */
// Port-level checks for the glyph formatter and their bind to the top level.
module sdgf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       pready,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [3:0] glyph_0_o,
  input logic [3:0] glyph_1_o,
  input logic [3:0] glyph_7_o
);
  import sdgf_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(glyph_0_o) && $stable(glyph_7_o))
    else $error("result item changed while stalled");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (glyph_0_o <= GLYPH_BLANK) && (glyph_7_o <= GLYPH_BLANK))
    else $error("glyph code out of range");

  a_left_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (glyph_0_o == GLYPH_BLANK) |-> (glyph_1_o == GLYPH_BLANK))
    else $error("row not left aligned");

  a_minus_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (glyph_1_o != GLYPH_MINUS) && (glyph_7_o != GLYPH_MINUS))
    else $error("minus glyph outside leftmost slot");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind signed_decimal_glyph_formatter_unit sdgf_checker u_sdgf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pready      (pready),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .glyph_0_o   (glyph_0_o),
  .glyph_1_o   (glyph_1_o),
  .glyph_7_o   (glyph_7_o)
);

/* sim/glyph_row_checker.sv */
// Checker: predicts glyph rows from accepted values and compares emitted rows.
module glyph_row_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [2:0]                    paddr_i,
  input  logic [31:0]                   pwdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [sdgf_pkg::VALUE_W-1:0]  value_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  sdgf_pkg::glyph_t              glyph_0_i,
  input  sdgf_pkg::glyph_t              glyph_1_i,
  input  sdgf_pkg::glyph_t              glyph_2_i,
  input  sdgf_pkg::glyph_t              glyph_3_i,
  input  sdgf_pkg::glyph_t              glyph_4_i,
  input  sdgf_pkg::glyph_t              glyph_5_i,
  input  sdgf_pkg::glyph_t              glyph_6_i,
  input  sdgf_pkg::glyph_t              glyph_7_i,
  output int unsigned                   mismatch_count_o,
  output int unsigned                   rows_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import sdgf_pkg::*;

  typedef glyph_t [MAX_SLOTS-1:0] glyph_row_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    glyph_row_t         row;
  } row_entry_t;

  localparam logic [2:0] SLOTS_ADDR = 3'(REG_DIGIT_SLOTS * 4);

  logic [SLOTS_W-1:0] digit_slots;
  row_entry_t         expected_rows[$];

  // Left-aligned decimal layout: optional minus, then digits MSB first, blanks after.
  function automatic glyph_row_t format_glyph_row(input logic [VALUE_W-1:0] raw,
                                                  input logic [SLOTS_W-1:0] slots);
    glyph_row_t         row;
    glyph_t             digits[BCD_DIGITS];
    logic [VALUE_W-1:0] mag;
    logic               neg;
    int unsigned        used;
    int unsigned        ndig;
    int unsigned        pos;
    neg  = raw[VALUE_W-1];
    // two's complement negate; the most negative value keeps magnitude 2^31
    mag  = neg ? (~raw + 1'b1) : raw;
    used = (slots > MAX_SLOTS) ? MAX_SLOTS : slots;
    ndig = 0;
    pos  = 0;
    for (int i = 0; i < MAX_SLOTS; i++) row[i] = GLYPH_BLANK;
    if (mag == '0) begin
      digits[0] = glyph_t'(0);
      ndig = 1;
    end else begin
      while (mag != '0) begin
        digits[ndig] = glyph_t'(mag % 10);
        ndig++;
        mag = mag / 10;
      end
    end
    if (neg && pos < used) begin
      row[pos] = GLYPH_MINUS;
      pos++;
    end
    while (ndig > 0 && pos < used) begin
      ndig--;
      row[pos] = digits[ndig];
      pos++;
    end
    return row;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    row_entry_t  entry;
    glyph_row_t  actual;
    int unsigned errs;
    if (!rst_ni) begin
      digit_slots = SLOTS_W'(MAX_SLOTS);
      expected_rows.delete();
      mismatch_count_o <= 0;
      rows_pending_o   <= 0;
    end else begin
      errs   = 0;
      actual = {glyph_7_i, glyph_6_i, glyph_5_i, glyph_4_i,
                glyph_3_i, glyph_2_i, glyph_1_i, glyph_0_i};
      if (out_valid_i && out_ready_i) begin
        if (expected_rows.size() == 0) begin
          $display("%0t: expected no glyph row, actual %h", $realtime, actual);
          errs = errs + 1;
        end else begin
          entry = expected_rows.pop_front();
          for (int i = 0; i < MAX_SLOTS; i++) begin
            if (actual[i] !== entry.row[i]) begin
              $display("%0t: value %0d glyph_%0d expected %0d actual %0d",
                       $realtime, $signed(entry.value), i, entry.row[i], actual[i]);
              errs = errs + 1;
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        entry.value   = value_i;
        entry.row     = format_glyph_row(value_i, digit_slots);
        expected_rows = {expected_rows, entry};
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == SLOTS_ADDR)
        digit_slots = pwdata_i[SLOTS_W-1:0];
      mismatch_count_o <= mismatch_count_o + errs;
      rows_pending_o   <= expected_rows.size();
    end
  end

endmodule

/* sim/testbench.sv */
// Testbench top: clock, reset, value and register stimulus, verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sdgf_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned LATENCY_CYCLES = 45;
  localparam int unsigned ITEMS_PER_PHASE = 30;
  localparam logic [2:0]  SLOTS_ADDR = 3'(REG_DIGIT_SLOTS * 4);

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready_o;
  logic [VALUE_W-1:0] value = '0;
  logic               out_valid_o;
  logic               out_ready = 1'b0;
  glyph_t             glyph_o[MAX_SLOTS];
  int unsigned        mismatch_count;
  int unsigned        rows_pending;
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_idle_pct = 0;
  int unsigned        quiet_cycles = 0;

  signed_decimal_glyph_formatter_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .value_i     (value),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .glyph_0_o   (glyph_o[0]),
    .glyph_1_o   (glyph_o[1]),
    .glyph_2_o   (glyph_o[2]),
    .glyph_3_o   (glyph_o[3]),
    .glyph_4_o   (glyph_o[4]),
    .glyph_5_o   (glyph_o[5]),
    .glyph_6_o   (glyph_o[6]),
    .glyph_7_o   (glyph_o[7])
  );

  glyph_row_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready_o),
    .value_i          (value),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready),
    .glyph_0_i        (glyph_o[0]),
    .glyph_1_i        (glyph_o[1]),
    .glyph_2_i        (glyph_o[2]),
    .glyph_3_i        (glyph_o[3]),
    .glyph_4_i        (glyph_o[4]),
    .glyph_5_i        (glyph_o[5]),
    .glyph_6_i        (glyph_o[6]),
    .glyph_7_i        (glyph_o[7]),
    .mismatch_count_o (mismatch_count),
    .rows_pending_o   (rows_pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("signed_decimal_glyph_formatter_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Leaves valid high after acceptance; stop_sending drops it, and the next call may drop it during idle cycles.
  task automatic send_value(input logic [VALUE_W-1:0] v);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_valid <= 1'b0;
  endtask

  task automatic drain_rows();
    stop_sending();
    while (rows_pending != 0) @(negedge clk_i);
  endtask

  task automatic write_digit_slots(input logic [SLOTS_W-1:0] slots);
    drain_rows();
    repeat (LATENCY_CYCLES) @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SLOTS_ADDR;
    pwdata  <= 32'(slots);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mix of raw bit patterns, values of a chosen digit count, edge values, and powers of ten.
  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned kind;
    int unsigned ndig;
    longint      lo;
    longint      hi;
    longint      mag;
    kind = $urandom_range(9);
    if (kind < 4) return $urandom();
    if (kind < 8) begin
      ndig = $urandom_range(1, 10);
      lo = 1;
      for (int i = 1; i < ndig; i++) lo = lo * 10;
      hi = lo * 10 - 1;
      if (ndig == 1) lo = 0;
      if (hi > 64'sd2147483647) hi = 64'sd2147483647;
      mag = lo + (longint'($urandom()) % (hi - lo + 1));
      return $urandom_range(1) ? VALUE_W'(-mag) : VALUE_W'(mag);
    end
    if (kind == 8) begin
      case ($urandom_range(3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return '0;
        default: return '1;
      endcase
    end
    // powers of ten and their neighbors, where digit counts change
    mag = 1;
    for (int i = $urandom_range(9); i > 0; i--) mag = mag * 10;
    mag = mag - $urandom_range(1);
    return $urandom_range(1) ? VALUE_W'(-mag) : VALUE_W'(mag);
  endfunction

  initial begin
    logic [SLOTS_W-1:0] slot_plan[4];
    int unsigned        idle_plan[3][2];
    slot_plan = '{4'd8, 4'd1, 4'd0, 4'd15};
    idle_plan = '{'{30, 65}, '{65, 30}, '{0, 0}};

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset slot count of eight
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hffff_ffff);
    send_value(32'd9);
    send_value(32'd10);
    send_value(-32'sd10);
    send_value(32'h7fff_ffff);
    send_value(32'h8000_0000);
    send_value(32'd12345678);
    send_value(32'd123456789);
    send_value(-32'sd1234567);
    send_value(-32'sd12345678);
    send_value(32'd1000000000);
    // no slot in use: all blank
    write_digit_slots(4'd0);
    send_value(32'd5);
    send_value(-32'sd5);
    // single slot: negative shows only the minus
    write_digit_slots(4'd1);
    send_value(32'd7);
    send_value(-32'sd7);
    send_value(32'd0);
    // counts above eight saturate
    write_digit_slots(4'd15);
    send_value(32'h8000_0000);
    send_value(32'd98765432);
    write_digit_slots(4'd2);
    send_value(-32'sd3);
    send_value(32'd42);

    for (int m = 0; m < 3; m++) begin
      send_idle_pct = idle_plan[m][0];
      recv_idle_pct = idle_plan[m][1];
      for (int p = 0; p < 6; p++) begin
        write_digit_slots(p < 4 ? slot_plan[p] : SLOTS_W'($urandom_range(15)));
        for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
          if ($urandom_range(39) == 0) drain_rows();
          send_value(pick_value());
        end
      end
    end

    drain_rows();
    repeat (LATENCY_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("signed_decimal_glyph_formatter_unit verification clean");
    end else begin
      $display("signed_decimal_glyph_formatter_unit verification failed");
    end
    $finish;
  end

endmodule
